>>> rtl/aegs_pkg.sv
// shared widths, register indexes, step constants and beat structs
// for the auto exposure / gain step block; no dependencies
package aegs_pkg;

   localparam int BRIGHT_W = 8;
   localparam int GAIN_W   = 16;
   localparam int EXPO_W   = 24;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_REFERENCE_LEVEL  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_FLOOR       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_CEILING     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_EXPOSURE_FLOOR   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_EXPOSURE_CEILING = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_EXPOSURE_ENABLE  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_ENABLE      = 3'd6;

   localparam logic [BRIGHT_W-1:0] RESET_REFERENCE_LEVEL = 8'd128;

   localparam int BRIGHT_FULL = 255;
   localparam int DEAD_BAND   = 13;
   localparam int GAIN_STEP_K = 10;
   localparam int EXPO_STEP_K = 10000;
   localparam int TRADE_GAIN  = 1;
   localparam int TRADE_EXPO  = 1000;

   // step = trunc(k * mag / 255) as (mag * ceil(k * 2^shift / 255)) >> shift,
   // exact for every 8-bit magnitude since 255 * 255 < 2^shift
   localparam int RECIP_SHIFT = 17;
   localparam longint GSTEP_MUL =
      (longint'(GAIN_STEP_K) * (longint'(1) << RECIP_SHIFT) + BRIGHT_FULL - 1) / BRIGHT_FULL;
   localparam longint ESTEP_MUL =
      (longint'(EXPO_STEP_K) * (longint'(1) << RECIP_SHIFT) + BRIGHT_FULL - 1) / BRIGHT_FULL;
   localparam int GMUL_W  = $clog2(GSTEP_MUL + 1);
   localparam int EMUL_W  = $clog2(ESTEP_MUL + 1);
   localparam int GPROD_W = BRIGHT_W + GMUL_W;
   localparam int EPROD_W = BRIGHT_W + EMUL_W;

   localparam int COUNT_W = 3;
   localparam logic [COUNT_W-1:0] ACT_COUNT     = 3'd4;
   localparam logic [COUNT_W-1:0] COUNT_RESTART = 3'd1;

   typedef struct packed {
      logic [EXPO_W-1:0]   current_exposure;
      logic [GAIN_W-1:0]   current_gain;
      logic [BRIGHT_W-1:0] frame_brightness;
   } aegs_item_type;

   typedef struct packed {
      logic [BRIGHT_W-1:0] reference_level;
      logic [GAIN_W-1:0]   gain_floor;
      logic [GAIN_W-1:0]   gain_ceiling;
      logic [EXPO_W-1:0]   exposure_floor;
      logic [EXPO_W-1:0]   exposure_ceiling;
   } aegs_cfg_type;

   typedef struct packed {
      logic [EXPO_W-1:0] new_exposure;
      logic              exposure_write;
      logic [GAIN_W-1:0] new_gain;
      logic              gain_write;
   } aegs_result_type;

endpackage

>>> rtl/aegs_calc.sv
// correction step for one frame: brightness offset, step sizes, clamps
// depends on aegs_pkg
module aegs_calc (
   input  aegs_pkg::aegs_item_type   item,
   input  logic                      act,
   input  aegs_pkg::aegs_cfg_type    cfg,
   output aegs_pkg::aegs_result_type result
);

   logic [aegs_pkg::BRIGHT_W:0]    diff;
   logic [aegs_pkg::BRIGHT_W-1:0]  mag;
   logic [aegs_pkg::GPROD_W-1:0]   gprod;
   logic [aegs_pkg::EPROD_W-1:0]   eprod;
   logic [aegs_pkg::GPROD_W-aegs_pkg::RECIP_SHIFT-1:0] gstep;
   logic [aegs_pkg::EPROD_W-aegs_pkg::RECIP_SHIFT-1:0] estep;
   logic [aegs_pkg::GAIN_W:0]      gsub, gadd, gtrade;
   logic [aegs_pkg::EXPO_W:0]      esub, eadd, etrade;
   logic [aegs_pkg::GAIN_W-1:0]    gain_dn, gain_up, gain_tr;
   logic [aegs_pkg::EXPO_W-1:0]    expo_dn, expo_up, expo_tr;
   logic                           big_offset;
   logic                           gain_above;
   logic                           expo_below;

   always_comb begin
      diff  = {1'b0, item.frame_brightness} - {1'b0, cfg.reference_level};
      mag   = diff[aegs_pkg::BRIGHT_W] ? aegs_pkg::BRIGHT_W'(-diff)
                                       : diff[aegs_pkg::BRIGHT_W-1:0];
      gprod = aegs_pkg::GPROD_W'(mag) * aegs_pkg::GPROD_W'(aegs_pkg::GSTEP_MUL);
      eprod = aegs_pkg::EPROD_W'(mag) * aegs_pkg::EPROD_W'(aegs_pkg::ESTEP_MUL);
      gstep = gprod[aegs_pkg::GPROD_W-1:aegs_pkg::RECIP_SHIFT];
      estep = eprod[aegs_pkg::EPROD_W-1:aegs_pkg::RECIP_SHIFT];
      big_offset = mag >= aegs_pkg::BRIGHT_W'(aegs_pkg::DEAD_BAND);

      gain_above = item.current_gain > cfg.gain_floor;
      expo_below = item.current_exposure < cfg.exposure_ceiling;

      // downward moves clamp at the floor, borrow means below zero
      gsub   = {1'b0, item.current_gain} - (aegs_pkg::GAIN_W+1)'(gstep);
      gtrade = {1'b0, item.current_gain} - (aegs_pkg::GAIN_W+1)'(aegs_pkg::TRADE_GAIN);
      esub   = {1'b0, item.current_exposure} - (aegs_pkg::EXPO_W+1)'(estep);
      gain_dn = (gsub[aegs_pkg::GAIN_W] || gsub[aegs_pkg::GAIN_W-1:0] < cfg.gain_floor)
                ? cfg.gain_floor : gsub[aegs_pkg::GAIN_W-1:0];
      gain_tr = (gtrade[aegs_pkg::GAIN_W] || gtrade[aegs_pkg::GAIN_W-1:0] < cfg.gain_floor)
                ? cfg.gain_floor : gtrade[aegs_pkg::GAIN_W-1:0];
      expo_dn = (esub[aegs_pkg::EXPO_W] || esub[aegs_pkg::EXPO_W-1:0] < cfg.exposure_floor)
                ? cfg.exposure_floor : esub[aegs_pkg::EXPO_W-1:0];

      // upward moves clamp at the ceiling
      gadd   = {1'b0, item.current_gain} + (aegs_pkg::GAIN_W+1)'(gstep);
      eadd   = {1'b0, item.current_exposure} + (aegs_pkg::EXPO_W+1)'(estep);
      etrade = {1'b0, item.current_exposure} + (aegs_pkg::EXPO_W+1)'(aegs_pkg::TRADE_EXPO);
      gain_up = (gadd > {1'b0, cfg.gain_ceiling})
                ? cfg.gain_ceiling : gadd[aegs_pkg::GAIN_W-1:0];
      expo_up = (eadd > {1'b0, cfg.exposure_ceiling})
                ? cfg.exposure_ceiling : eadd[aegs_pkg::EXPO_W-1:0];
      expo_tr = (etrade > {1'b0, cfg.exposure_ceiling})
                ? cfg.exposure_ceiling : etrade[aegs_pkg::EXPO_W-1:0];

      result = '0;
      if (act) begin
         if (big_offset) begin
            if (!diff[aegs_pkg::BRIGHT_W]) begin
               // too bright
               if (gain_above) begin
                  result.gain_write = 1'b1;
                  result.new_gain   = gain_dn;
               end else begin
                  result.exposure_write = 1'b1;
                  result.new_exposure   = expo_dn;
               end
            end else begin
               // too dark
               if (expo_below) begin
                  result.exposure_write = 1'b1;
                  result.new_exposure   = expo_up;
               end else begin
                  result.gain_write = 1'b1;
                  result.new_gain   = gain_up;
               end
            end
         end else if (gain_above && expo_below) begin
            // near target: trade gain for exposure
            result.gain_write     = 1'b1;
            result.new_gain       = gain_tr;
            result.exposure_write = 1'b1;
            result.new_exposure   = expo_tr;
         end
      end
   end

endmodule

>>> rtl/auto_exposure_gain_step_top.sv
// top level of the auto exposure / gain step block: stream ports,
// control registers, frame counter and the two-stage pipeline
// depends on aegs_pkg and aegs_calc
//
// an accepted frame is held in the input stage, then the result stage
// throughput: one frame per cycle without rsp stalls, set by the single
//   registered pass through the step multipliers and clamps of aegs_calc
// reset (synchronous, active high): pipeline empty, frame counter zero,
//   control registers at their defaults (reference 128, limits 0, enables 1)
module auto_exposure_gain_step_top (
   input  logic                              clock,
   input  logic                              reset,

   // frame in
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] frame_brightness, [23:8] current_gain, [47:24] current_exposure
   input  logic [47:0]                       req_tdata,

   // correction out
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [15:0] new_gain, [39:16] new_exposure
   output logic [39:0]                       rsp_tdata,
   // [0] gain_write, [1] exposure_write
   output logic [1:0]                        rsp_tuser,

   // control register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [aegs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [aegs_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // control registers
   aegs_pkg::aegs_cfg_type cfg_ff, cfg_in;
   logic                   exposure_enable_ff, exposure_enable_in;
   logic                   gain_enable_ff, gain_enable_in;

   // frame counter, picks the acting frames
   logic [aegs_pkg::COUNT_W-1:0] count_ff, count_in;

   // input stage
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_act_ff, s1_act_in;
   aegs_pkg::aegs_item_type s1_item_ff, s1_item_in;

   // result stage
   logic                      rsp_valid_ff, rsp_valid_in;
   aegs_pkg::aegs_result_type rsp_result_ff, rsp_result_in;
   aegs_pkg::aegs_result_type step_result;

   logic req_beat;
   logic advance;
   logic running;
   logic acting;

   // control writes are always taken
   assign csr_ready = 1'b1;

   // the whole pipeline moves whenever the result slot is free or drains
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   assign running = exposure_enable_ff || gain_enable_ff;
   assign acting  = running && (count_ff >= aegs_pkg::ACT_COUNT);

   always_comb begin
      cfg_in             = cfg_ff;
      exposure_enable_in = exposure_enable_ff;
      gain_enable_in     = gain_enable_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            aegs_pkg::REG_REFERENCE_LEVEL:
               cfg_in.reference_level = csr_wdata[aegs_pkg::BRIGHT_W-1:0];
            aegs_pkg::REG_GAIN_FLOOR:
               cfg_in.gain_floor = csr_wdata[aegs_pkg::GAIN_W-1:0];
            aegs_pkg::REG_GAIN_CEILING:
               cfg_in.gain_ceiling = csr_wdata[aegs_pkg::GAIN_W-1:0];
            aegs_pkg::REG_EXPOSURE_FLOOR:
               cfg_in.exposure_floor = csr_wdata[aegs_pkg::EXPO_W-1:0];
            aegs_pkg::REG_EXPOSURE_CEILING:
               cfg_in.exposure_ceiling = csr_wdata[aegs_pkg::EXPO_W-1:0];
            aegs_pkg::REG_EXPOSURE_ENABLE:
               exposure_enable_in = csr_wdata[0];
            aegs_pkg::REG_GAIN_ENABLE:
               gain_enable_in = csr_wdata[0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // frame counter steps on every accepted frame while either enable is set;
   // an acting frame restarts it so the next act comes four frames later
   always_comb begin
      count_in = count_ff;
      if (req_beat && running) begin
         count_in = acting ? aegs_pkg::COUNT_RESTART : count_ff + 1'b1;
      end
   end

   // input stage holds the frame and whether it acts
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_act_in   = s1_act_ff;
      s1_item_in  = s1_item_ff;
      if (req_beat) begin
         s1_valid_in = 1'b1;
         s1_act_in   = acting;
         s1_item_in  = aegs_pkg::aegs_item_type'(req_tdata);
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   aegs_calc u_calc (
      .item   (s1_item_ff),
      .act    (s1_act_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   // result stage, loads when it is free or being drained
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      if (advance) begin
         rsp_valid_in  = s1_valid_ff;
         rsp_result_in = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reference_level  <= aegs_pkg::RESET_REFERENCE_LEVEL;
         cfg_ff.gain_floor       <= '0;
         cfg_ff.gain_ceiling     <= '0;
         cfg_ff.exposure_floor   <= '0;
         cfg_ff.exposure_ceiling <= '0;
         exposure_enable_ff      <= 1'b1;
         gain_enable_ff          <= 1'b1;
         count_ff                <= '0;
         s1_valid_ff             <= 1'b0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         cfg_ff             <= cfg_in;
         exposure_enable_ff <= exposure_enable_in;
         gain_enable_ff     <= gain_enable_in;
         count_ff           <= count_in;
         s1_valid_ff        <= s1_valid_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      s1_act_ff     <= s1_act_in;
      s1_item_ff    <= s1_item_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_result_ff.new_exposure, rsp_result_ff.new_gain};
   assign rsp_tuser  = {rsp_result_ff.exposure_write, rsp_result_ff.gain_write};

endmodule

>>> rtl/aegs_checker.sv
// port-level checks for the auto exposure / gain step block, bound to the top
// depends on auto_exposure_gain_step_top
module aegs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // pipeline is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp beat offered right after reset");

   // a gain value that is not flagged for writing reads as zero
   a_gain_zero_unwritten: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[15:0] == 16'd0))
      else $error("new_gain nonzero without gain_write");

   // same for exposure
   a_expo_zero_unwritten: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[1]) |-> (rsp_tdata[39:16] == 24'd0))
      else $error("new_exposure nonzero without exposure_write");

   // a stalled rsp beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("rsp beat changed while stalled");

endmodule

bind auto_exposure_gain_step_top aegs_checker u_aegs_checker (.*);
